// File: src/sfr_pkg.sv
// shared constants and types for the serial frame receiver
`default_nettype none
package sfr_pkg;

   localparam int MaxFrame = 32;
   localparam int PosWidth = $clog2(MaxFrame);
   localparam int SumWidth = 9;

   localparam logic [7:0] HdrFirst      = 8'hAA;
   localparam logic [7:0] HdrSecond     = 8'hBB;
   localparam logic [7:0] AddrBroadcast = 8'hFF;
   localparam logic [7:0] AddrGroup     = 8'hEE;
   localparam logic [7:0] OwnAddrReset  = 8'h01;

   typedef logic [PosWidth-1:0] pos_type;

   typedef enum logic [3:0] {
      EV_IGNORED   = 4'd0,
      EV_HEADER    = 4'd1,
      EV_SOURCE    = 4'd2,
      EV_DEST_OK   = 4'd3,
      EV_LEN_OK    = 4'd4,
      EV_PAYLOAD   = 4'd5,
      EV_GOOD      = 4'd6,
      EV_BAD_DEST  = 4'd7,
      EV_BAD_LEN   = 4'd8,
      EV_BAD_CHECK = 4'd9
   } event_type;

   typedef struct packed {
      logic       step;
      logic [7:0] rx_byte;
   } step_type;

endpackage
`default_nettype wire

// File: src/sfr_deframer.sv
// frame position tracking, running xor and per-byte event decode
`default_nettype none
module sfr_deframer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sfr_pkg::step_type   step_in,
   input  wire logic [7:0]          own_address,
   output sfr_pkg::event_type       event_out
);

   sfr_pkg::pos_type position_ff, position_in;
   logic [7:0]       length_ff, length_in;
   logic [7:0]       xor_ff, xor_in;
   logic [7:0]       b;
   logic [sfr_pkg::SumWidth-1:0] len_total;
   logic [sfr_pkg::SumWidth-1:0] payload_end;
   logic             dest_ok;

   assign b = step_in.rx_byte;
   assign len_total = {1'b0, b} + sfr_pkg::SumWidth'(6);
   assign payload_end = {1'b0, length_ff} + sfr_pkg::SumWidth'(4);
   assign dest_ok = (b == own_address) || (b == sfr_pkg::AddrBroadcast) ||
                    (b == sfr_pkg::AddrGroup);

   always_comb begin
      position_in = position_ff;
      length_in   = length_ff;
      xor_in      = xor_ff;
      event_out   = sfr_pkg::EV_IGNORED;
      priority if (position_ff == sfr_pkg::PosWidth'(0)) begin
         if (b == sfr_pkg::HdrFirst) begin
            event_out   = sfr_pkg::EV_HEADER;
            position_in = sfr_pkg::PosWidth'(1);
         end
      end else if (position_ff == sfr_pkg::PosWidth'(1)) begin
         // a wrong second header byte is not retried as a first one
         if (b == sfr_pkg::HdrSecond) begin
            event_out   = sfr_pkg::EV_HEADER;
            position_in = sfr_pkg::PosWidth'(2);
         end else begin
            position_in = sfr_pkg::PosWidth'(0);
         end
      end else if (position_ff == sfr_pkg::PosWidth'(2)) begin
         xor_in      = b;
         event_out   = sfr_pkg::EV_SOURCE;
         position_in = sfr_pkg::PosWidth'(3);
      end else if (position_ff == sfr_pkg::PosWidth'(3)) begin
         if (dest_ok) begin
            xor_in      = xor_ff ^ b;
            event_out   = sfr_pkg::EV_DEST_OK;
            position_in = sfr_pkg::PosWidth'(4);
         end else begin
            event_out   = sfr_pkg::EV_BAD_DEST;
            position_in = sfr_pkg::PosWidth'(0);
         end
      end else if (position_ff == sfr_pkg::PosWidth'(4)) begin
         if (len_total > sfr_pkg::SumWidth'(sfr_pkg::MaxFrame)) begin
            event_out   = sfr_pkg::EV_BAD_LEN;
            position_in = sfr_pkg::PosWidth'(0);
         end else begin
            length_in   = b;
            xor_in      = xor_ff ^ b;
            event_out   = sfr_pkg::EV_LEN_OK;
            position_in = sfr_pkg::PosWidth'(5);
         end
      end else if (sfr_pkg::SumWidth'(position_ff) <= payload_end) begin
         xor_in      = xor_ff ^ b;
         event_out   = sfr_pkg::EV_PAYLOAD;
         position_in = position_ff + sfr_pkg::PosWidth'(1);
      end else begin
         event_out   = (b == xor_ff) ? sfr_pkg::EV_GOOD : sfr_pkg::EV_BAD_CHECK;
         position_in = sfr_pkg::PosWidth'(0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         length_ff   <= '0;
         xor_ff      <= '0;
      end else if (step_in.step) begin
         position_ff <= position_in;
         length_ff   <= length_in;
         xor_ff      <= xor_in;
      end
   end

endmodule
`default_nettype wire

// File: src/serial_frame_receiver.sv
// top level: input register, deframer and result register
// Usage:
//   req_* carries one received byte per transaction (tdata[7:0]).
//   rsp_* returns one event code per byte, in order (tdata[3:0], upper bits 0).
//   csr_* writes the node address; csr_ready is always high, write only when idle.
// A taken byte waits in the input register until the result register is free, then
//   its decoded event is registered there and rsp_tvalid rises.
// Throughput: one byte per cycle while rsp_tready stays high; the deframer's
//   position/xor registers advance on every step.
// A byte is still taken while a finished event waits if the input register is
//   empty; with both registers full, every stalled rsp cycle also holds off req.
// When rsp_tready is low, the result holds, the input register fills and then
//   req_tready drops until the result is taken.
// Reset: both registers empty, hunting for a header, xor and length cleared,
//   node address back to 0x01.
`default_nettype none
module serial_frame_receiver (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [3:0] event_res, [7:4] zero
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_data     // [7:0] own_address
);

   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic               rsp_valid_ff;
   sfr_pkg::event_type rsp_event_ff;
   logic [7:0]         own_address_ff;
   logic               out_free;
   logic               advance;
   sfr_pkg::step_type  step;
   sfr_pkg::event_type event_res;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign csr_ready  = 1'b1;

   assign step.step    = advance;
   assign step.rx_byte = in_byte_ff;

   sfr_deframer u_deframer (
      .clock       (clock),
      .reset       (reset),
      .step_in     (step),
      .own_address (own_address_ff),
      .event_out   (event_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         own_address_ff <= sfr_pkg::OwnAddrReset;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (csr_valid && csr_ready) begin
            own_address_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         rsp_event_ff <= event_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_event_ff};

endmodule
`default_nettype wire

// File: verif/tb.sv
// testbench for serial_frame_receiver: directed and random framed byte traffic checked against a deframer model
`timescale 1ns / 1ps
module tb;

   localparam int CycleLimit = 300000;
   localparam int DrainCycles = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = 8'h00;

   // deframer model state
   sfr_pkg::pos_type hunt_pos = '0;
   logic [7:0] frame_len = 8'h00;
   logic [7:0] frame_xor = 8'h00;
   logic [7:0] node_addr = sfr_pkg::OwnAddrReset;

   sfr_pkg::event_type pending_events[$];
   sfr_pkg::event_type want_event;
   int         mismatch_count = 0;
   int         cycle_count = 0;
   int         bytes_sent = 0;
   int         idle_pct = 0;
   int         stall_pct = 0;

   serial_frame_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // role of one received byte, advancing the frame position
   function automatic sfr_pkg::event_type deframe(input logic [7:0] rx);
      sfr_pkg::event_type ev;
      ev = sfr_pkg::EV_IGNORED;
      if (hunt_pos == 0) begin
         if (rx == sfr_pkg::HdrFirst) begin
            ev = sfr_pkg::EV_HEADER;
            hunt_pos = 1;
         end
      end else if (hunt_pos == 1) begin
         // a wrong second byte is not retried as a first header byte
         if (rx == sfr_pkg::HdrSecond) begin
            ev = sfr_pkg::EV_HEADER;
            hunt_pos = 2;
         end else begin
            hunt_pos = 0;
         end
      end else if (hunt_pos == 2) begin
         frame_xor = rx;
         ev = sfr_pkg::EV_SOURCE;
         hunt_pos = 3;
      end else if (hunt_pos == 3) begin
         if (rx == node_addr || rx == sfr_pkg::AddrBroadcast ||
             rx == sfr_pkg::AddrGroup) begin
            frame_xor ^= rx;
            ev = sfr_pkg::EV_DEST_OK;
            hunt_pos = 4;
         end else begin
            ev = sfr_pkg::EV_BAD_DEST;
            hunt_pos = 0;
         end
      end else if (hunt_pos == 4) begin
         if (int'(rx) + 6 > sfr_pkg::MaxFrame) begin
            ev = sfr_pkg::EV_BAD_LEN;
            hunt_pos = 0;
         end else begin
            frame_len = rx;
            frame_xor ^= rx;
            ev = sfr_pkg::EV_LEN_OK;
            hunt_pos = 5;
         end
      end else if (int'(hunt_pos) <= int'(frame_len) + 4) begin
         frame_xor ^= rx;
         ev = sfr_pkg::EV_PAYLOAD;
         hunt_pos = hunt_pos + 1'b1;
      end else begin
         ev = (rx == frame_xor) ? sfr_pkg::EV_GOOD : sfr_pkg::EV_BAD_CHECK;
         hunt_pos = 0;
      end
      return ev;
   endfunction

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_events.size() == 0) begin
               $error("event_res: expected none, got %0d", rsp_tdata[3:0]);
               mismatch_count++;
            end else begin
               want_event = pending_events.pop_front();
               if (rsp_tdata[3:0] !== want_event) begin
                  $error("event_res: expected %0d, got %0d", want_event, rsp_tdata[3:0]);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready)
            node_addr = csr_data;
         if (req_tvalid && req_tready)
            pending_events.push_back(deframe(req_tdata));
      end
   end

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic send_byte(input logic [7:0] rx);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] src, input logic [7:0] dst,
                             input logic [7:0] len, input bit check_ok);
      logic [7:0] sum;
      logic [7:0] data;
      send_byte(sfr_pkg::HdrFirst);
      send_byte(sfr_pkg::HdrSecond);
      send_byte(src);
      send_byte(dst);
      send_byte(len);
      sum = src ^ dst ^ len;
      if (int'(len) + 6 <= sfr_pkg::MaxFrame) begin
         for (int i = 0; i < int'(len); i++) begin
            data = 8'($urandom);
            sum ^= data;
            send_byte(data);
         end
         send_byte(check_ok ? sum : sum ^ 8'($urandom_range(1, 255)));
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_address(input logic [7:0] addr);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= addr;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_hunting();
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   task automatic test_broken_header();
      send_byte(sfr_pkg::HdrFirst);
      send_byte(sfr_pkg::HdrFirst);
      send_byte(sfr_pkg::HdrSecond);
   endtask

   task automatic test_good_frames();
      send_frame(8'h00, sfr_pkg::OwnAddrReset, 8'd0, 1'b1);
      send_frame(8'hFF, sfr_pkg::AddrBroadcast, 8'd1, 1'b1);
   endtask

   task automatic test_rejects();
      send_frame(8'h5A, 8'h02, 8'd0, 1'b1);
      send_frame(8'h3C, sfr_pkg::AddrGroup, 8'(sfr_pkg::MaxFrame - 5), 1'b1);
      send_frame(8'hC3, sfr_pkg::AddrGroup, 8'd1, 1'b0);
   endtask

   task automatic test_address();
      set_address(8'h00);
      send_frame(8'h11, 8'h00, 8'd0, 1'b1);
      send_frame(8'h22, sfr_pkg::OwnAddrReset, 8'd0, 1'b1);
   endtask

   task automatic test_random_traffic(input int count, input int idle, input int stall);
      int       start;
      int       pick;
      logic [7:0] dst;
      logic [7:0] len;
      idle_pct  = idle;
      stall_pct = stall;
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            case ($urandom_range(3))
               0: dst = node_addr;
               1: dst = sfr_pkg::AddrBroadcast;
               2: dst = sfr_pkg::AddrGroup;
               default: dst = 8'($urandom);
            endcase
            pick = $urandom_range(99);
            if (pick < 5)
               len = 8'(sfr_pkg::MaxFrame - 6);
            else if (pick < 10)
               len = 8'($urandom_range(sfr_pkg::MaxFrame - 5, 255));
            else
               len = 8'($urandom_range(0, 8));
            send_frame(8'($urandom), dst, len, $urandom_range(99) < 85);
         end else if (pick < 87) begin
            // frame cut short, whatever follows lands inside it
            send_byte(sfr_pkg::HdrFirst);
            send_byte(sfr_pkg::HdrSecond);
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_hunting();
      test_broken_header();
      test_good_frames();
      test_rejects();
      test_address();

      set_address(8'hFF);
      test_random_traffic(400, 0, 0);
      set_address(8'($urandom));
      test_random_traffic(400, 72, 0);
      set_address(8'h00);
      test_random_traffic(400, 0, 72);
      set_address(sfr_pkg::OwnAddrReset);
      test_random_traffic(400, 19, 19);

      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (pending_events.size() != 0) begin
         $error("%0d events never arrived", pending_events.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: filelist.f
src/sfr_pkg.sv
src/sfr_deframer.sv
src/serial_frame_receiver.sv
verif/tb.sv
